/* rtl/hsfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_pkg: shared types and constants of the sensor frame checker
// Byte positions, check codes, the frame record passed from front to back,
// the CRC-8 step and the divide-by-full-scale helper.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  typedef enum logic [1:0] {
    CHECK_OK         = 2'd0,
    CHECK_FIRST_BAD  = 2'd1,
    CHECK_SECOND_BAD = 2'd2
  } check_e;

  typedef enum logic {
    KIND_MEASURE = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  // byte positions inside a frame
  localparam logic [2:0] POS_FIRST_HI  = 3'd0;
  localparam logic [2:0] POS_FIRST_LO  = 3'd1;
  localparam logic [2:0] POS_FIRST_CRC = 3'd2;
  localparam logic [2:0] POS_SECOND_HI = 3'd3;
  localparam logic [2:0] POS_SECOND_LO = 3'd4;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam int unsigned TEMP_SCALE  = 17500;
  localparam int unsigned HUM_SCALE   = 10000;
  localparam int unsigned TEMP_OFFSET = 4500;
  localparam int unsigned FULL_SCALE  = 65535;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    check_e      check;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic        convert;
  } frame_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(p / 65535) for p below 2^31 with a quotient below 2^15
  function automatic logic [14:0] div_full_scale(input logic [30:0] p);
    logic [14:0] q0;
    logic [16:0] sum;
    q0  = p[30:16];
    sum = {2'b00, q0} + {1'b0, p[15:0]};
    return q0 + {14'd0, (sum >= 17'(FULL_SCALE))};
  endfunction

endpackage

/* rtl/hsfc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_front: byte tracker
// Follows the byte position, runs the CRC and collects the words; on the
// last byte of a frame it pushes a finished frame record into the queue.
// ----------------------------------------------------------------------------
module hsfc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  frame_start_i,
  input  hsfc_pkg::kind_e       frame_kind_i,
  output logic                  push_o,
  output hsfc_pkg::frame_t      frame_o
);

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_eff, crc_next;
  logic [15:0] first_q, first_d;
  logic [15:0] second_q, second_d;
  logic        bad_q, bad_d, bad_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 3'd0;
      crc_q    <= hsfc_pkg::CRC_INIT;
      first_q  <= 16'd0;
      second_q <= 16'd0;
      bad_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      first_q  <= first_d;
      second_q <= second_d;
      bad_q    <= bad_d;
    end
  end

  always_comb begin
    // a frame start drops whatever partial frame is in progress
    pos_eff  = frame_start_i ? hsfc_pkg::POS_FIRST_HI : pos_q;
    crc_eff  = frame_start_i ? hsfc_pkg::CRC_INIT : crc_q;
    bad_eff  = frame_start_i ? 1'b0 : bad_q;
    crc_next = hsfc_pkg::crc8_update(crc_eff, rx_byte_i);

    pos_d    = pos_q;
    crc_d    = crc_q;
    first_d  = first_q;
    second_d = second_q;
    bad_d    = bad_q;
    push_o   = 1'b0;
    frame_o  = '{check: hsfc_pkg::CHECK_OK, first_word: first_q,
                 second_word: second_q, convert: 1'b0};

    if (accept_i) begin
      pos_d = pos_eff + 3'd1;
      crc_d = crc_eff;
      bad_d = bad_eff;
      if (frame_kind_i == hsfc_pkg::KIND_STATUS) begin
        if (pos_eff == hsfc_pkg::POS_FIRST_HI) begin
          first_d  = {rx_byte_i, 8'h00};
          second_d = 16'd0;
        end else if (pos_eff == hsfc_pkg::POS_FIRST_LO) begin
          first_d = {first_q[15:8], rx_byte_i};
        end
        if (pos_eff < hsfc_pkg::POS_FIRST_CRC) begin
          crc_d = crc_next;
        end else begin
          push_o             = 1'b1;
          frame_o.check      = (crc_eff == rx_byte_i) ? hsfc_pkg::CHECK_OK
                                                      : hsfc_pkg::CHECK_FIRST_BAD;
          frame_o.second_word = 16'd0;
          pos_d              = 3'd0;
          crc_d              = hsfc_pkg::CRC_INIT;
          bad_d              = 1'b0;
        end
      end else begin
        unique case (pos_eff)
          hsfc_pkg::POS_FIRST_HI: begin
            first_d = {rx_byte_i, 8'h00};
            crc_d   = crc_next;
          end
          hsfc_pkg::POS_FIRST_LO: begin
            first_d = {first_q[15:8], rx_byte_i};
            crc_d   = crc_next;
          end
          hsfc_pkg::POS_FIRST_CRC: begin
            bad_d = (crc_eff != rx_byte_i);
            crc_d = hsfc_pkg::CRC_INIT;
          end
          hsfc_pkg::POS_SECOND_HI: begin
            second_d = {rx_byte_i, 8'h00};
            crc_d    = crc_next;
          end
          hsfc_pkg::POS_SECOND_LO: begin
            second_d = {second_q[15:8], rx_byte_i};
            crc_d    = crc_next;
          end
          default: begin
            push_o = 1'b1;
            if (bad_eff) begin
              frame_o.check = hsfc_pkg::CHECK_FIRST_BAD;
            end else if (crc_eff != rx_byte_i) begin
              frame_o.check = hsfc_pkg::CHECK_SECOND_BAD;
            end else begin
              frame_o.check   = hsfc_pkg::CHECK_OK;
              frame_o.convert = 1'b1;
            end
            pos_d = 3'd0;
            crc_d = hsfc_pkg::CRC_INIT;
            bad_d = 1'b0;
          end
        endcase
      end
    end
  end

endmodule

/* rtl/hsfc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_queue: frame record queue
// Short FIFO of finished frame records between the byte tracker and the
// conversion pipeline.
// ----------------------------------------------------------------------------
module hsfc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hsfc_pkg::frame_t push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output hsfc_pkg::frame_t pop_data_o
);

  hsfc_pkg::frame_t                   entry_q [hsfc_pkg::QUEUE_DEPTH];
  logic [hsfc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [hsfc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [hsfc_pkg::QUEUE_PTR_W:0]     count_q, count_d;
  logic                               do_push, do_pop;

  localparam logic [hsfc_pkg::QUEUE_PTR_W-1:0] LastPtr =
    hsfc_pkg::QUEUE_PTR_W'(hsfc_pkg::QUEUE_DEPTH - 1);
  localparam logic [hsfc_pkg::QUEUE_PTR_W:0] FullCount =
    (hsfc_pkg::QUEUE_PTR_W + 1)'(hsfc_pkg::QUEUE_DEPTH);

  assign valid_o    = (count_q != '0);
  assign full_o     = (count_q == FullCount);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/hsfc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_back: conversion pipeline
// Stage one scales the raw words, stage two divides by full scale, applies
// the temperature offset and loads the output register.
// ----------------------------------------------------------------------------
module hsfc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  hsfc_pkg::frame_t    job_i,
  output logic                job_pop_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [1:0]          check_result_o,
  output logic [15:0]         first_word_o,
  output logic [15:0]         second_word_o,
  output logic signed [14:0]  temperature_centi_o,
  output logic [13:0]         humidity_centi_o
);

  logic             s1_valid_q;
  hsfc_pkg::frame_t s1_job_q;
  logic [30:0]      s1_temp_prod_q;
  logic [29:0]      s1_hum_prod_q;
  logic             out_valid_q;
  hsfc_pkg::frame_t out_job_q;
  logic [14:0]      out_temp_q, out_temp_d;
  logic [13:0]      out_hum_q, out_hum_d;
  logic             out_ready, s1_ready;
  logic [14:0]      temp_raw, hum_raw;
  logic [15:0]      temp_off;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign job_pop_o = job_valid_i && s1_ready;

  always_comb begin
    temp_raw = hsfc_pkg::div_full_scale(s1_temp_prod_q);
    hum_raw  = hsfc_pkg::div_full_scale({1'b0, s1_hum_prod_q});
    temp_off = {1'b0, temp_raw} - 16'(hsfc_pkg::TEMP_OFFSET);
    // zero both readings on CRC error or status frame
    out_temp_d = s1_job_q.convert ? temp_off[14:0] : 15'd0;
    out_hum_d  = s1_job_q.convert ? hum_raw[13:0] : 14'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= job_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      s1_job_q       <= job_i;
      s1_temp_prod_q <= 31'(hsfc_pkg::TEMP_SCALE) * {15'd0, job_i.first_word};
      s1_hum_prod_q  <= 30'(hsfc_pkg::HUM_SCALE) * {14'd0, job_i.second_word};
    end
    if (out_ready && s1_valid_q) begin
      out_job_q  <= s1_job_q;
      out_temp_q <= out_temp_d;
      out_hum_q  <= out_hum_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign check_result_o      = out_job_q.check;
  assign first_word_o        = out_job_q.first_word;
  assign second_word_o       = out_job_q.second_word;
  assign temperature_centi_o = out_temp_q;
  assign humidity_centi_o    = out_hum_q;

endmodule

/* rtl/humidity_sensor_frame_checker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_frame_checker_core: sensor frame CRC check and conversion
// Checks CRC-8 protected words from the sensor and converts readings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per request (rx_byte_i), frame_start_i
//   marks the first byte of a frame and drops any partial frame.
//   Output channel: one request per complete frame, after its last byte:
//   check code, both raw words, temperature and humidity in hundredths.
//   Config channel: cfg_data_i selects the frame kind (0 six-byte measure,
//   1 three-byte status); write only while the block is idle.
//   Throughput: one byte per cycle while in_stall_o is low. The byte
//   tracker handles a byte in the cycle it is taken; frame records cross a
//   two-entry queue into a two-stage conversion pipeline (scale multiply,
//   then divide by full scale), so a result passes the queue, the stage-one
//   register and the output register before it shows on out_valid_o.
//   Output stall holds the result register; the pipeline and queue fill,
//   and in_stall_o rises only once the queue is full.
//   Reset: frame kind measure, byte position zero, CRC 0xFF, no results.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_checker_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_start_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          check_result_o,
  output logic [15:0]         first_word_o,
  output logic [15:0]         second_word_o,
  output logic signed [14:0]  temperature_centi_o,
  output logic [13:0]         humidity_centi_o
);

  hsfc_pkg::kind_e  frame_kind_q;
  logic             in_accept;
  logic             push;
  hsfc_pkg::frame_t push_frame;
  logic             queue_valid, queue_full, queue_pop;
  hsfc_pkg::frame_t queue_frame;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = queue_full;
  assign in_accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_kind_q <= hsfc_pkg::KIND_MEASURE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_kind_q <= hsfc_pkg::kind_e'(cfg_data_i);
    end
  end

  hsfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .frame_kind_i  (frame_kind_q),
    .push_o        (push),
    .frame_o       (push_frame)
  );

  hsfc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_frame),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .full_o      (queue_full),
    .pop_data_o  (queue_frame)
  );

  hsfc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .job_valid_i         (queue_valid),
    .job_i               (queue_frame),
    .job_pop_o           (queue_pop),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .check_result_o      (check_result_o),
    .first_word_o        (first_word_o),
    .second_word_o       (second_word_o),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o)
  );

endmodule

/* rtl/hsfc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_checker: port-level checks of the sensor frame checker
// Watches the output channel for held results and legal result contents.
// ----------------------------------------------------------------------------
module hsfc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         check_result_o,
  input logic [15:0]        first_word_o,
  input logic signed [14:0] temperature_centi_o,
  input logic [13:0]        humidity_centi_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(first_word_o)
                                    && $stable(check_result_o))
  else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (check_result_o == hsfc_pkg::CHECK_OK)
                 || (check_result_o == hsfc_pkg::CHECK_FIRST_BAD)
                 || (check_result_o == hsfc_pkg::CHECK_SECOND_BAD))
  else $error("illegal check code");

  // failed frames carry no converted readings
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (check_result_o != hsfc_pkg::CHECK_OK)
      |-> (temperature_centi_o == 15'sd0) && (humidity_centi_o == 14'd0))
  else $error("readings on a failed frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (humidity_centi_o <= 14'(hsfc_pkg::HUM_SCALE))
                 && (temperature_centi_o >= -15'sd4500))
  else $error("reading out of range");

endmodule

bind humidity_sensor_frame_checker_core hsfc_checker u_hsfc_checker (.*);
